// File: hdl/ncc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ncc_pkg
// types and codes shared by the nonzero coordinate collector
// ----------------------------------------------------------------------------
package ncc_pkg;

  localparam int SIZE_BITS = 16;
  localparam int SIZE_REGS = 4;

  localparam logic [1:0] ACT_PUSH    = 2'd0;
  localparam logic [1:0] ACT_READ    = 2'd1;
  localparam logic [1:0] ACT_RESTART = 2'd2;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_DROPPED = 2'd1;
  localparam logic [1:0] STAT_RANGE   = 2'd2;

  localparam logic [2:0] REG_LAYOUT_ORDER = 3'd0;
  localparam logic [2:0] REG_RANK         = 3'd1;
  localparam logic [2:0] REG_SIZE_DIM0    = 3'd2;
  localparam logic [2:0] REG_SIZE_DIM1    = 3'd3;
  localparam logic [2:0] REG_SIZE_DIM2    = 3'd4;
  localparam logic [2:0] REG_SIZE_DIM3    = 3'd5;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] element_bits;
    logic [9:0]  position;
    logic [1:0]  dimension;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [10:0] nonzero_count;
    logic [15:0] coordinate;
    logic [11:0] output_offset;
  } result_t;

endpackage : ncc_pkg
`default_nettype wire

// File: hdl/ncc_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ncc_store
// coordinate store: one write port, one read port with registered data
// ----------------------------------------------------------------------------
module ncc_store #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : ncc_store
`default_nettype wire

// File: hdl/nonzero_coordinate_collector_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nonzero_coordinate_collector_top
// collects coordinates of nonzero tensor elements and serves coordinate reads
// ----------------------------------------------------------------------------
// A push, a restart or an unused command leaves busy low, so a new command
// may be started in the very next cycle. A read passes through a second
// state, as the coordinate store returns registered read data; busy is high
// in that state. Every command gives one result, shown for exactly one cycle
// with done high, in the cycle after the command's last cycle; the receiver
// must take it then. The user must write configuration via cfg_we, cfg_index
// and cfg_data only while no command is in progress; nothing enforces this.
module nonzero_coordinate_collector_top
  import ncc_pkg::*;
#(
  parameter int MAX_DIMS      = 4,
  parameter int COORD_BITS    = 16,
  parameter int MAX_POSITIONS = 1024
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  output logic          busy,
  input  wire cmd_t     cmd,
  input  wire logic     cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output logic          done,
  output result_t       result
);

  localparam int AW = $clog2(MAX_POSITIONS);
  localparam int CW = $clog2(MAX_POSITIONS + 1);
  localparam int RW = MAX_DIMS * COORD_BITS;

  logic                 layout_order;
  logic [2:0]           rank;
  logic [SIZE_BITS-1:0] size_regs [SIZE_REGS];

  logic [SIZE_BITS-1:0] counters [MAX_DIMS];
  logic [SIZE_BITS-1:0] cnt_next [MAX_DIMS];
  logic [SIZE_BITS-1:0] ext [MAX_DIMS];
  logic                 tensor_complete;
  logic [CW-1:0]        found_count;
  logic                 wrap;

  state_t  state, state_next;
  logic    done_next;
  result_t res_next;

  logic [9:0] rd_pos;
  logic [1:0] rd_dim;
  logic [3:0] eff_rank;

  logic          accept;
  logic          is_zero;
  logic          full;
  logic          push_ok;
  logic          store_we;
  logic [RW-1:0] wr_row;
  logic [RW-1:0] rd_row;
  logic [AW-1:0] rd_addr;

  logic [COORD_BITS-1:0] coord_sel;
  logic                  pos_ok;
  logic                  dim_ok;
  logic [31:0]           off0;
  logic [31:0]           off1;

  assign accept  = start && !busy;
  assign busy    = (state == ST_READ);
  assign is_zero = (cmd.element_bits[30:0] == 31'd0);
  assign full    = (32'(found_count) == MAX_POSITIONS);
  assign push_ok = !tensor_complete && !full;
  assign store_we = accept && (cmd.action == ACT_PUSH) && push_ok && !is_zero;
  assign rd_addr = AW'(32'(cmd.position));

  always_comb begin
    if (rank == 3'd0) begin
      eff_rank = 4'd1;
    end else if (32'(rank) > MAX_DIMS) begin
      eff_rank = 4'(MAX_DIMS);
    end else begin
      eff_rank = 4'(rank);
    end
  end

  for (genvar g = 0; g < MAX_DIMS; g++) begin : g_ext
    if (g < SIZE_REGS) begin : g_reg
      assign ext[g] = (size_regs[g] == '0) ? SIZE_BITS'(1) : size_regs[g];
    end else begin : g_one
      assign ext[g] = SIZE_BITS'(1);
    end
    assign wr_row[g*COORD_BITS +: COORD_BITS] =
      (g < int'(eff_rank)) ? COORD_BITS'(counters[g]) : '0;
  end

  // counter advance, last dimension in use fastest
  always_comb begin
    logic             carry;
    logic [SIZE_BITS:0] inc;
    carry = 1'b1;
    inc = '0;
    for (int d = 0; d < MAX_DIMS; d++) begin
      cnt_next[d] = counters[d];
    end
    for (int d = MAX_DIMS - 1; d >= 0; d--) begin
      if ((d < int'(eff_rank)) && carry) begin
        inc = {1'b0, counters[d]} + (SIZE_BITS + 1)'(1);
        if (inc < {1'b0, ext[d]}) begin
          cnt_next[d] = inc[SIZE_BITS-1:0];
          carry = 1'b0;
        end else begin
          cnt_next[d] = '0;
        end
      end
    end
    wrap = carry;
  end

  ncc_store #(
    .DEPTH (MAX_POSITIONS),
    .WIDTH (RW)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (found_count[AW-1:0]),
    .wdata (wr_row),
    .re    (accept && (cmd.action == ACT_READ)),
    .raddr (rd_addr),
    .rdata (rd_row)
  );

  // read result terms
  assign coord_sel = rd_row[int'(rd_dim) * COORD_BITS +: COORD_BITS];
  assign pos_ok = 32'(rd_pos) < 32'(found_count);
  assign dim_ok = 4'(rd_dim) < eff_rank;
  assign off0 = 32'(rd_pos) * 32'(eff_rank) + 32'(rd_dim);
  assign off1 = 32'(rd_dim) * 32'(found_count) + 32'(rd_pos);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    done_next = 1'b0;
    res_next = '0;
    res_next.nonzero_count = 11'(found_count);
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (cmd.action)
            ACT_PUSH: begin
              done_next = 1'b1;
              if (!push_ok) begin
                res_next.status = STAT_DROPPED;
              end else if (!is_zero) begin
                res_next.nonzero_count = 11'(found_count + CW'(1));
              end
            end
            ACT_READ: begin
              state_next = ST_READ;
            end
            ACT_RESTART: begin
              done_next = 1'b1;
              res_next.nonzero_count = '0;
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        state_next = ST_IDLE;
        done_next = 1'b1;
        if (pos_ok && dim_ok) begin
          res_next.coordinate = 16'(32'(coord_sel));
          res_next.output_offset = layout_order ? off1[11:0] : off0[11:0];
        end else begin
          res_next.status = STAT_RANGE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      layout_order <= 1'b0;
      rank <= 3'd1;
      for (int d = 0; d < SIZE_REGS; d++) begin
        size_regs[d] <= SIZE_BITS'(1);
      end
      for (int d = 0; d < MAX_DIMS; d++) begin
        counters[d] <= '0;
      end
      tensor_complete <= 1'b0;
      found_count <= '0;
      done <= 1'b0;
    end else begin
      done <= done_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_LAYOUT_ORDER: layout_order <= cfg_data[0];
          REG_RANK:         rank <= cfg_data[2:0];
          REG_SIZE_DIM0:    size_regs[0] <= cfg_data;
          REG_SIZE_DIM1:    size_regs[1] <= cfg_data;
          REG_SIZE_DIM2:    size_regs[2] <= cfg_data;
          REG_SIZE_DIM3:    size_regs[3] <= cfg_data;
          default: begin
          end
        endcase
      end
      if (accept) begin
        case (cmd.action)
          ACT_PUSH: begin
            if (push_ok) begin
              counters <= cnt_next;
              if (wrap) begin
                tensor_complete <= 1'b1;
              end
              if (!is_zero) begin
                found_count <= found_count + CW'(1);
              end
            end
          end
          ACT_RESTART: begin
            for (int d = 0; d < MAX_DIMS; d++) begin
              counters[d] <= '0;
            end
            tensor_complete <= 1'b0;
            found_count <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    result <= res_next;
    if (accept && (cmd.action == ACT_READ)) begin
      rd_pos <= cmd.position;
      rd_dim <= cmd.dimension;
    end
  end

  // busy only in the read state that follows an accepted read
  a_busy_after_read: assert property (@(posedge clk) disable iff (rst)
    busy |-> $past(start && !busy && (cmd.action == ACT_READ)))
    else $error("busy without a read transfer");

  // every result follows a non-read command or the end of a read
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy || (start && (cmd.action != ACT_READ))))
    else $error("result without a command");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(found_count) <= MAX_POSITIONS)
    else $error("nonzero count beyond store depth");

endmodule : nonzero_coordinate_collector_top
`default_nettype wire

// File: test/nonzero_coordinate_collector_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nonzero_coordinate_collector_checker
// Watches the command, result and register ports of the nonzero coordinate
// collector, keeps its own copy of the counters, coordinate store and
// registers, predicts the result of every accepted command and compares each
// result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module nonzero_coordinate_collector_checker
  import ncc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire cmd_t        cmd,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        done,
  input  wire result_t     result,
  output int               outstanding,
  output int               collected,
  output int               failures
);

  localparam int MAX_DIMS      = 4;
  localparam int MAX_POSITIONS = 1024;

  logic        layout_sel;
  logic [2:0]  rank_reg;
  logic [15:0] extent_reg [SIZE_REGS];

  logic [15:0] coord_ctr [MAX_DIMS];
  logic        tensor_done;
  logic [10:0] found;
  logic [15:0] coord_mem [MAX_POSITIONS][MAX_DIMS];

  result_t     expected_results [$];

  function automatic int unsigned active_rank();
    if (rank_reg == 3'd0) return 1;
    if (rank_reg > MAX_DIMS) return MAX_DIMS;
    return 32'(rank_reg);
  endfunction

  function automatic int unsigned extent_of(input int d);
    return (extent_reg[d] == 16'd0) ? 1 : 32'(extent_reg[d]);
  endfunction

  // last dimension in use runs fastest; wrap of dimension 0 ends the tensor
  function automatic void advance_coords(input int unsigned rk);
    int k;
    int unsigned nxt;
    k = int'(rk);
    while (k > 0) begin
      nxt = coord_ctr[k-1] + 1;
      if (nxt < extent_of(k-1)) begin
        coord_ctr[k-1] = nxt[15:0];
        return;
      end
      coord_ctr[k-1] = '0;
      k--;
    end
    tensor_done = 1'b1;
  endfunction

  function automatic result_t predict_result(input cmd_t c);
    result_t     r;
    int unsigned rk;
    int unsigned ofs;
    r = '0;
    r.status = STAT_OK;
    rk = active_rank();
    case (c.action)
      ACT_PUSH: begin
        if (tensor_done || found >= MAX_POSITIONS) begin
          r.status = STAT_DROPPED;
        end else begin
          if (c.element_bits[30:0] != '0) begin
            for (int d = 0; d < MAX_DIMS; d++)
              coord_mem[found][d] = (d < rk) ? coord_ctr[d] : '0;
            found++;
          end
          advance_coords(rk);
        end
      end
      ACT_READ: begin
        if (c.position >= found || c.dimension >= rk) begin
          r.status = STAT_RANGE;
        end else begin
          r.coordinate = coord_mem[c.position][c.dimension];
          if (layout_sel)
            ofs = c.dimension * found + c.position;
          else
            ofs = c.position * rk + c.dimension;
          r.output_offset = ofs[11:0];
        end
      end
      ACT_RESTART: begin
        for (int d = 0; d < MAX_DIMS; d++) coord_ctr[d] = '0;
        tensor_done = 1'b0;
        found = '0;
      end
      default: ;
    endcase
    r.nonzero_count = found;
    return r;
  endfunction

  function automatic void add_expected(input result_t r);
    expected_results = {expected_results, r};
  endfunction

  function automatic void compare_field(input string name, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      failures++;
    end
  endfunction

  function automatic void check_result(input result_t got);
    result_t want;
    if (expected_results.size() == 0) begin
      $error("result: no transfer outstanding, actual %p", got);
      failures++;
      return;
    end
    want = expected_results.pop_front();
    compare_field("status", 32'(want.status), 32'(got.status));
    compare_field("nonzero_count", 32'(want.nonzero_count), 32'(got.nonzero_count));
    compare_field("coordinate", 32'(want.coordinate), 32'(got.coordinate));
    compare_field("output_offset", 32'(want.output_offset), 32'(got.output_offset));
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      layout_sel = 1'b0;
      rank_reg = 3'd1;
      for (int d = 0; d < SIZE_REGS; d++) extent_reg[d] = 16'd1;
      for (int d = 0; d < MAX_DIMS; d++) coord_ctr[d] = '0;
      tensor_done = 1'b0;
      found = '0;
      expected_results.delete();
      failures = 0;
    end else begin
      if (done) check_result(result);
      if (start && !busy) add_expected(predict_result(cmd));
      if (cfg_we) begin
        case (cfg_index)
          REG_LAYOUT_ORDER: layout_sel = cfg_data[0];
          REG_RANK:         rank_reg = cfg_data[2:0];
          REG_SIZE_DIM0:    extent_reg[0] = cfg_data;
          REG_SIZE_DIM1:    extent_reg[1] = cfg_data;
          REG_SIZE_DIM2:    extent_reg[2] = cfg_data;
          REG_SIZE_DIM3:    extent_reg[3] = cfg_data;
          default: ;
        endcase
      end
    end
    outstanding <= expected_results.size();
    collected <= 32'(found);
  end

endmodule

// File: test/nonzero_coordinate_collector_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nonzero_coordinate_collector_top_tb
// Drives the nonzero coordinate collector with a directed set of corner
// cases, then with random register settings and command streams in bursts,
// including a full fill of the coordinate store; a checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
module nonzero_coordinate_collector_top_tb;
  import ncc_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 1850;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  cmd_t        cmd = '0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        done;
  result_t     result;

  int outstanding;
  int collected;
  int failures;
  int items_sent = 0;
  int burst_left = 1;

  always #6 clk = ~clk;

  nonzero_coordinate_collector_top DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .done      (done),
    .result    (result)
  );

  nonzero_coordinate_collector_checker coord_check (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .done        (done),
    .result      (result),
    .outstanding (outstanding),
    .collected   (collected),
    .failures    (failures)
  );

  // random filler for the fields a command does not use
  function automatic cmd_t random_fill();
    cmd_t c;
    c.action = 2'($urandom());
    c.element_bits = $urandom();
    c.position = 10'($urandom());
    c.dimension = 2'($urandom());
    return c;
  endfunction

  function automatic cmd_t push_cmd(input logic [31:0] bits);
    cmd_t c;
    c = random_fill();
    c.action = ACT_PUSH;
    c.element_bits = bits;
    return c;
  endfunction

  function automatic cmd_t read_cmd(input logic [9:0] pos, input logic [1:0] dim);
    cmd_t c;
    c = random_fill();
    c.action = ACT_READ;
    c.position = pos;
    c.dimension = dim;
    return c;
  endfunction

  function automatic cmd_t plain_cmd(input logic [1:0] act);
    cmd_t c;
    c = random_fill();
    c.action = act;
    return c;
  endfunction

  function automatic logic [31:0] pick_element(input bit nonzero);
    logic [31:0] e;
    case ($urandom_range(0, 9))
      0: e = 32'h0000_0000;
      1: e = 32'h8000_0000;
      2: e = 32'h7FC0_0000;
      3: e = {$urandom_range(0, 1) == 1, 31'h0000_0001};
      default: e = $urandom();
    endcase
    if (nonzero && e[30:0] == '0) e[0] = 1'b1;
    return e;
  endfunction

  function automatic cmd_t random_cmd(input int push_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < push_pct)
      return push_cmd(pick_element(1'b0));
    if (roll < 96) begin
      if ($urandom_range(0, 9) == 0)
        return read_cmd(10'($urandom()), 2'($urandom()));
      return read_cmd(10'($urandom_range(0, collected)), 2'($urandom()));
    end
    if (roll < 98) return plain_cmd(ACT_RESTART);
    return plain_cmd(ACT_UNUSED);
  endfunction

  // burst pacing on the sender side
  task automatic pace();
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        if ($urandom_range(0, 7) == 0)
          repeat ($urandom_range(10, 30)) @(posedge clk);
        else
          repeat ($urandom_range(1, 5)) @(posedge clk);
      end
    end
  endtask

  task automatic send(input cmd_t c);
    start <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    pace();
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic configure(input logic lo, input logic [2:0] rk, input logic [15:0] s0,
                           input logic [15:0] s1, input logic [15:0] s2,
                           input logic [15:0] s3);
    drain();
    write_reg(REG_LAYOUT_ORDER, {15'd0, lo});
    write_reg(REG_RANK, {13'd0, rk});
    write_reg(REG_SIZE_DIM0, s0);
    write_reg(REG_SIZE_DIM1, s1);
    write_reg(REG_SIZE_DIM2, s2);
    write_reg(REG_SIZE_DIM3, s3);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_extent();
    case ($urandom_range(0, 11))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(1, 65535));
      default: return 16'($urandom_range(1, 5));
    endcase
  endfunction

  initial begin
    logic [2:0] rk;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset settings: rank 1, extent 1, so one push completes the tensor
    send(push_cmd(32'h8000_0000));
    send(push_cmd(32'h3F80_0000));
    send(plain_cmd(ACT_RESTART));
    send(push_cmd(32'h7FC0_0000));
    send(read_cmd(10'd0, 2'd0));
    send(read_cmd(10'd1, 2'd0));
    send(read_cmd(10'd0, 2'd1));
    send(plain_cmd(ACT_UNUSED));
    send(push_cmd(32'hFFFF_FFFF));

    // oversized rank and zero extent
    configure(1'b1, 3'd7, 16'd2, 16'd0, 16'd3, 16'hFFFF);
    send(plain_cmd(ACT_RESTART));
    send(push_cmd(32'h0000_0001));
    send(push_cmd(32'h0000_0000));
    send(push_cmd(32'h8000_0001));
    send(push_cmd(32'hFFFF_FFFF));
    send(read_cmd(10'd2, 2'd3));
    send(read_cmd(10'd0, 2'd2));
    send(read_cmd(10'h3FF, 2'd3));

    // shrink extents under a running counter
    configure(1'b0, 3'd4, 16'd1, 16'd1, 16'd1, 16'd2);
    send(push_cmd(32'h3F80_0000));
    send(push_cmd(32'h4000_0000));
    send(read_cmd(10'd3, 2'd3));

    while (items_sent < ITEM_TARGET) begin
      if (items_sent > 400 && items_sent < 500) begin
        // fill the coordinate store, then read it under both layouts
        configure(1'b0, 3'd4, 16'd4, 16'd4, 16'd8, 16'd16);
        send(plain_cmd(ACT_RESTART));
        repeat (1030) send(push_cmd(pick_element(1'b1)));
        repeat (30) send(read_cmd(10'($urandom()), 2'($urandom())));
        send(read_cmd(10'h3FF, 2'd3));
        configure(1'b1, 3'd4, 16'd4, 16'd4, 16'd8, 16'd16);
        repeat (30) send(read_cmd(10'($urandom()), 2'($urandom())));
        send(read_cmd(10'h3FF, 2'd3));
        send(push_cmd(32'h0000_0000));
      end
      rk = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7))
                                       : 3'($urandom_range(1, 4));
      configure(1'($urandom_range(0, 1)), rk, pick_extent(), pick_extent(),
                pick_extent(), pick_extent());
      if ($urandom_range(0, 3) != 0) send(plain_cmd(ACT_RESTART));
      repeat ($urandom_range(20, 90)) send(random_cmd(60));
    end

    drain();
    repeat (4) @(posedge clk);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
